@@ sv/mcct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marching cubes triangulator package
// Payload types, edge geometry and the triangle table shared by the block.
// ----------------------------------------------------------------------------
package mcct_pkg;

  localparam int unsigned NumCorners = 8;
  localparam int unsigned NumEdges   = 12;
  localparam int unsigned MaxVerts   = 15;

  typedef struct packed {
    logic [7:0]  cube_x;
    logic [7:0]  cube_y;
    logic [7:0]  cube_z;
    logic [15:0] corner_0;
    logic [15:0] corner_1;
    logic [15:0] corner_2;
    logic [15:0] corner_3;
    logic [15:0] corner_4;
    logic [15:0] corner_5;
    logic [15:0] corner_6;
    logic [15:0] corner_7;
  } cube_req_t;

  typedef struct packed {
    logic [8:0]  vertex_x2;
    logic [8:0]  vertex_y2;
    logic [8:0]  vertex_z2;
    logic [3:0]  edge_index;
    logic [7:0]  case_index;
    logic [11:0] crossed_edges;
    logic        triangle_end;
    logic        cube_last;
  } vertex_req_t;

  // One triangle table row: up to fifteen 4-bit edges and a vertex count.
  typedef struct packed {
    logic [3:0]  count;
    logic [59:0] edges;
  } tri_row_t;

  // Doubled midpoint offset of an edge, packed as {x, y, z}.
  function automatic logic [5:0] edge_mid2(input logic [3:0] e);
    logic [5:0] r;
    begin
      case (e)
        4'd0:    r = {2'd1, 2'd0, 2'd0};
        4'd1:    r = {2'd2, 2'd1, 2'd0};
        4'd2:    r = {2'd1, 2'd2, 2'd0};
        4'd3:    r = {2'd0, 2'd1, 2'd0};
        4'd4:    r = {2'd1, 2'd0, 2'd2};
        4'd5:    r = {2'd2, 2'd1, 2'd2};
        4'd6:    r = {2'd1, 2'd2, 2'd2};
        4'd7:    r = {2'd0, 2'd1, 2'd2};
        4'd8:    r = {2'd0, 2'd0, 2'd1};
        4'd9:    r = {2'd2, 2'd0, 2'd1};
        4'd10:   r = {2'd2, 2'd2, 2'd1};
        4'd11:   r = {2'd0, 2'd2, 2'd1};
        default: r = {2'd1, 2'd0, 2'd0};
      endcase
      return r;
    end
  endfunction

  // Crossed edge mask from the case index.
  function automatic logic [11:0] edge_mask(input logic [7:0] c);
    return {c[3] ^ c[7], c[2] ^ c[6], c[1] ^ c[5], c[0] ^ c[4],
            c[7] ^ c[4], c[6] ^ c[7], c[5] ^ c[6], c[4] ^ c[5],
            c[3] ^ c[0], c[2] ^ c[3], c[1] ^ c[2], c[0] ^ c[1]};
  endfunction

  // Builds a row from a hex string, first edge in the low nibble.
  function automatic tri_row_t mk(input logic [59:0] h, input int unsigned n);
    tri_row_t r;
    logic [59:0] v;
    begin
      v = '0;
      for (int i = 0; i < 15; i++) begin
        if (i < n) v[i*4 +: 4] = h[(n-1-i)*4 +: 4];
      end
      r.count = 4'(n);
      r.edges = v;
      return r;
    end
  endfunction

  // Triangle table lookup.
  function automatic tri_row_t tri_row(input logic [7:0] c);
    tri_row_t r;
    begin
      case (c)
        8'd0: r = mk(60'h0, 0);
        8'd1: r = mk(60'h083, 3);
        8'd2: r = mk(60'h019, 3);
        8'd3: r = mk(60'h183981, 6);
        8'd4: r = mk(60'h12a, 3);
        8'd5: r = mk(60'h08312a, 6);
        8'd6: r = mk(60'h92a029, 6);
        8'd7: r = mk(60'h2832a8a98, 9);
        8'd8: r = mk(60'h3b2, 3);
        8'd9: r = mk(60'h0b28b0, 6);
        8'd10: r = mk(60'h19023b, 6);
        8'd11: r = mk(60'h1b219b98b, 9);
        8'd12: r = mk(60'h3a1ba3, 6);
        8'd13: r = mk(60'h0a108a8ba, 9);
        8'd14: r = mk(60'h3903b9ba9, 9);
        8'd15: r = mk(60'h98aa8b, 6);
        8'd16: r = mk(60'h478, 3);
        8'd17: r = mk(60'h430734, 6);
        8'd18: r = mk(60'h019847, 6);
        8'd19: r = mk(60'h419471731, 9);
        8'd20: r = mk(60'h12a847, 6);
        8'd21: r = mk(60'h34730412a, 9);
        8'd22: r = mk(60'h92a902847, 9);
        8'd23: r = mk(60'h2a9297273794, 12);
        8'd24: r = mk(60'h8473b2, 6);
        8'd25: r = mk(60'hb47b24204, 9);
        8'd26: r = mk(60'h90184723b, 9);
        8'd27: r = mk(60'h47b94b9b2921, 12);
        8'd28: r = mk(60'h3a13ba784, 9);
        8'd29: r = mk(60'h1ba14b1047b4, 12);
        8'd30: r = mk(60'h47890b9bab03, 12);
        8'd31: r = mk(60'h47b4b99ba, 9);
        8'd32: r = mk(60'h954, 3);
        8'd33: r = mk(60'h954083, 6);
        8'd34: r = mk(60'h054150, 6);
        8'd35: r = mk(60'h854835315, 9);
        8'd36: r = mk(60'h12a954, 6);
        8'd37: r = mk(60'h30812a495, 9);
        8'd38: r = mk(60'h52a542402, 9);
        8'd39: r = mk(60'h2a5325354348, 12);
        8'd40: r = mk(60'h95423b, 6);
        8'd41: r = mk(60'h0b208b495, 9);
        8'd42: r = mk(60'h05401523b, 9);
        8'd43: r = mk(60'h21525828b485, 12);
        8'd44: r = mk(60'ha3ba13954, 9);
        8'd45: r = mk(60'h4950818a18ba, 12);
        8'd46: r = mk(60'h54050b5bab03, 12);
        8'd47: r = mk(60'h54858aa8b, 9);
        8'd48: r = mk(60'h978579, 6);
        8'd49: r = mk(60'h930953573, 9);
        8'd50: r = mk(60'h078017157, 9);
        8'd51: r = mk(60'h153357, 6);
        8'd52: r = mk(60'h978957a12, 9);
        8'd53: r = mk(60'ha12950530573, 12);
        8'd54: r = mk(60'h802825857a52, 12);
        8'd55: r = mk(60'h2a5253357, 9);
        8'd56: r = mk(60'h7957893b2, 9);
        8'd57: r = mk(60'h95797292027b, 12);
        8'd58: r = mk(60'h23b018178157, 12);
        8'd59: r = mk(60'hb21b17715, 9);
        8'd60: r = mk(60'h958857a13a3b, 12);
        8'd61: r = mk(60'h5705097b010aba0, 15);
        8'd62: r = mk(60'hba0b03a50807570, 15);
        8'd63: r = mk(60'hba57b5, 6);
        8'd64: r = mk(60'ha65, 3);
        8'd65: r = mk(60'h0835a6, 6);
        8'd66: r = mk(60'h9015a6, 6);
        8'd67: r = mk(60'h1831985a6, 9);
        8'd68: r = mk(60'h165261, 6);
        8'd69: r = mk(60'h165126308, 9);
        8'd70: r = mk(60'h965906026, 9);
        8'd71: r = mk(60'h598582526328, 12);
        8'd72: r = mk(60'h23ba65, 6);
        8'd73: r = mk(60'hb08b20a65, 9);
        8'd74: r = mk(60'h01923b5a6, 9);
        8'd75: r = mk(60'h5a61929b298b, 12);
        8'd76: r = mk(60'h63b653513, 9);
        8'd77: r = mk(60'h08b0b50515b6, 12);
        8'd78: r = mk(60'h3b6036065059, 12);
        8'd79: r = mk(60'h65969bb98, 9);
        8'd80: r = mk(60'h5a6478, 6);
        8'd81: r = mk(60'h43047365a, 9);
        8'd82: r = mk(60'h1905a6847, 9);
        8'd83: r = mk(60'ha65197173794, 12);
        8'd84: r = mk(60'h612651478, 9);
        8'd85: r = mk(60'h125526304347, 12);
        8'd86: r = mk(60'h847905065026, 12);
        8'd87: r = mk(60'h739794329596269, 15);
        8'd88: r = mk(60'h3b2784a65, 9);
        8'd89: r = mk(60'h5a647242027b, 12);
        8'd90: r = mk(60'h01947823b5a6, 12);
        8'd91: r = mk(60'h9219b294b7b45a6, 15);
        8'd92: r = mk(60'h8473b53515b6, 12);
        8'd93: r = mk(60'h51b5b610b7b404b, 15);
        8'd94: r = mk(60'h059065036b63847, 15);
        8'd95: r = mk(60'h65969b4797b9, 12);
        8'd96: r = mk(60'ha4964a, 6);
        8'd97: r = mk(60'h4a649a083, 9);
        8'd98: r = mk(60'ha01a60640, 9);
        8'd99: r = mk(60'h83181686461a, 12);
        8'd100: r = mk(60'h149124264, 9);
        8'd101: r = mk(60'h308129249264, 12);
        8'd102: r = mk(60'h024426, 6);
        8'd103: r = mk(60'h832824426, 9);
        8'd104: r = mk(60'ha49a64b23, 9);
        8'd105: r = mk(60'h08228b49a4a6, 12);
        8'd106: r = mk(60'h3b201606461a, 12);
        8'd107: r = mk(60'h64161a48121b8b1, 15);
        8'd108: r = mk(60'h964936913b63, 12);
        8'd109: r = mk(60'h8b1810b61914641, 15);
        8'd110: r = mk(60'h3b6360064, 9);
        8'd111: r = mk(60'h648b68, 6);
        8'd112: r = mk(60'h7a678a89a, 9);
        8'd113: r = mk(60'h0730a709a67a, 12);
        8'd114: r = mk(60'ha671a7178180, 12);
        8'd115: r = mk(60'ha67a71173, 9);
        8'd116: r = mk(60'h126168189867, 12);
        8'd117: r = mk(60'h269291679093739, 15);
        8'd118: r = mk(60'h780706602, 9);
        8'd119: r = mk(60'h732672, 6);
        8'd120: r = mk(60'h23ba68a89867, 12);
        8'd121: r = mk(60'h20727b09767a9a7, 15);
        8'd122: r = mk(60'h1801781a767a23b, 15);
        8'd123: r = mk(60'hb21b17a61671, 12);
        8'd124: r = mk(60'h896867916b63136, 15);
        8'd125: r = mk(60'h091b67, 6);
        8'd126: r = mk(60'h7807063b0b60, 12);
        8'd127: r = mk(60'h7b6, 3);
        8'd128: r = mk(60'h76b, 3);
        8'd129: r = mk(60'h308b76, 6);
        8'd130: r = mk(60'h019b76, 6);
        8'd131: r = mk(60'h819831b76, 9);
        8'd132: r = mk(60'ha126b7, 6);
        8'd133: r = mk(60'h12a3086b7, 9);
        8'd134: r = mk(60'h2902a96b7, 9);
        8'd135: r = mk(60'h6b72a3a83a98, 12);
        8'd136: r = mk(60'h723627, 6);
        8'd137: r = mk(60'h708760620, 9);
        8'd138: r = mk(60'h276237019, 9);
        8'd139: r = mk(60'h162186198876, 12);
        8'd140: r = mk(60'ha76a17137, 9);
        8'd141: r = mk(60'ha7617a187108, 12);
        8'd142: r = mk(60'h03707a0a96a7, 12);
        8'd143: r = mk(60'h76a7a88a9, 9);
        8'd144: r = mk(60'h684b86, 6);
        8'd145: r = mk(60'h36b306046, 9);
        8'd146: r = mk(60'h86b846901, 9);
        8'd147: r = mk(60'h946963931b36, 12);
        8'd148: r = mk(60'h6846b82a1, 9);
        8'd149: r = mk(60'h12a30b06b046, 12);
        8'd150: r = mk(60'h4b846b0292a9, 12);
        8'd151: r = mk(60'ha93a32943b36463, 15);
        8'd152: r = mk(60'h823842462, 9);
        8'd153: r = mk(60'h042462, 6);
        8'd154: r = mk(60'h190234246438, 12);
        8'd155: r = mk(60'h194142246, 9);
        8'd156: r = mk(60'h8138618466a1, 12);
        8'd157: r = mk(60'ha10a06604, 9);
        8'd158: r = mk(60'h4634386a3039a93, 15);
        8'd159: r = mk(60'ha946a4, 6);
        8'd160: r = mk(60'h49576b, 6);
        8'd161: r = mk(60'h083495b76, 9);
        8'd162: r = mk(60'h50154076b, 9);
        8'd163: r = mk(60'hb76834354315, 12);
        8'd164: r = mk(60'h954a1276b, 9);
        8'd165: r = mk(60'h6b712a083495, 12);
        8'd166: r = mk(60'h76b54a42a402, 12);
        8'd167: r = mk(60'h348354325a52b76, 15);
        8'd168: r = mk(60'h723762549, 9);
        8'd169: r = mk(60'h954086062687, 12);
        8'd170: r = mk(60'h362376150540, 12);
        8'd171: r = mk(60'h628687218485158, 15);
        8'd172: r = mk(60'h954a16176137, 12);
        8'd173: r = mk(60'h16a176107870954, 15);
        8'd174: r = mk(60'h40a4a503a6a737a, 15);
        8'd175: r = mk(60'h76a7a854a48a, 12);
        8'd176: r = mk(60'h6956b9b89, 9);
        8'd177: r = mk(60'h36b063056095, 12);
        8'd178: r = mk(60'h0b805b01556b, 12);
        8'd179: r = mk(60'h6b3635531, 9);
        8'd180: r = mk(60'h12a95b9b8b56, 12);
        8'd181: r = mk(60'h0b306b09656912a, 15);
        8'd182: r = mk(60'hb85b56805a52025, 15);
        8'd183: r = mk(60'h6b36352a3a53, 12);
        8'd184: r = mk(60'h589528562382, 12);
        8'd185: r = mk(60'h956960062, 9);
        8'd186: r = mk(60'h158180568382628, 15);
        8'd187: r = mk(60'h156216, 6);
        8'd188: r = mk(60'h13616a386569896, 15);
        8'd189: r = mk(60'ha10a06950560, 12);
        8'd190: r = mk(60'h03856a, 6);
        8'd191: r = mk(60'ha56, 3);
        8'd192: r = mk(60'hb5a75b, 6);
        8'd193: r = mk(60'hb5ab75830, 9);
        8'd194: r = mk(60'h5b75ab190, 9);
        8'd195: r = mk(60'ha75ab7981831, 12);
        8'd196: r = mk(60'hb12b71751, 9);
        8'd197: r = mk(60'h08312717572b, 12);
        8'd198: r = mk(60'h9759279022b7, 12);
        8'd199: r = mk(60'h75272b592328982, 15);
        8'd200: r = mk(60'h25a235375, 9);
        8'd201: r = mk(60'h820852875a25, 12);
        8'd202: r = mk(60'h9015a35373a2, 12);
        8'd203: r = mk(60'h982921872a25752, 15);
        8'd204: r = mk(60'h135375, 6);
        8'd205: r = mk(60'h087071175, 9);
        8'd206: r = mk(60'h903935537, 9);
        8'd207: r = mk(60'h987597, 6);
        8'd208: r = mk(60'h5845a8ab8, 9);
        8'd209: r = mk(60'h5045b05abb30, 12);
        8'd210: r = mk(60'h01984a8aba45, 12);
        8'd211: r = mk(60'hab4a45b34941314, 15);
        8'd212: r = mk(60'h2512852b8458, 12);
        8'd213: r = mk(60'h04b0b345b2b151b, 15);
        8'd214: r = mk(60'h0250592b5458b85, 15);
        8'd215: r = mk(60'h9452b3, 6);
        8'd216: r = mk(60'h25a352345384, 12);
        8'd217: r = mk(60'h5a2524420, 9);
        8'd218: r = mk(60'h3a235a385458019, 15);
        8'd219: r = mk(60'h5a2524192942, 12);
        8'd220: r = mk(60'h845853351, 9);
        8'd221: r = mk(60'h045105, 6);
        8'd222: r = mk(60'h845853905035, 12);
        8'd223: r = mk(60'h945, 3);
        8'd224: r = mk(60'h4b749b9ab, 9);
        8'd225: r = mk(60'h0834979b79ab, 12);
        8'd226: r = mk(60'h1ab1b414074b, 12);
        8'd227: r = mk(60'h3143481a474bab4, 15);
        8'd228: r = mk(60'h4b79b492b912, 12);
        8'd229: r = mk(60'h9749b791b2b1083, 15);
        8'd230: r = mk(60'hb74b42240, 9);
        8'd231: r = mk(60'hb74b42834324, 12);
        8'd232: r = mk(60'h29a279237749, 12);
        8'd233: r = mk(60'h9a7974a27870207, 15);
        8'd234: r = mk(60'h37a3a274a1a040a, 15);
        8'd235: r = mk(60'h1a2874, 6);
        8'd236: r = mk(60'h491417713, 9);
        8'd237: r = mk(60'h491417081871, 12);
        8'd238: r = mk(60'h403743, 6);
        8'd239: r = mk(60'h487, 3);
        8'd240: r = mk(60'h9a8ab8, 6);
        8'd241: r = mk(60'h30939bb9a, 9);
        8'd242: r = mk(60'h01a0a88ab, 9);
        8'd243: r = mk(60'h31ab3a, 6);
        8'd244: r = mk(60'h12b1b99b8, 9);
        8'd245: r = mk(60'h30939b1292b9, 12);
        8'd246: r = mk(60'h02b80b, 6);
        8'd247: r = mk(60'h32b, 3);
        8'd248: r = mk(60'h23828aa89, 9);
        8'd249: r = mk(60'h9a2092, 6);
        8'd250: r = mk(60'h23828a0181a8, 12);
        8'd251: r = mk(60'h1a2, 3);
        8'd252: r = mk(60'h138918, 6);
        8'd253: r = mk(60'h091, 3);
        8'd254: r = mk(60'h038, 3);
        default: r = mk(60'h0, 0);
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/mcct_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Corner classifier
// Compares one corner a cycle against the surface level with a single
// shared comparator and shifts the result into the case index.
// ----------------------------------------------------------------------------
module mcct_classify
  import mcct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumCorners*16-1:0] corners_i,
  input  logic [15:0]            level_i,
  output logic                   done_o,
  output logic [7:0]             case_o
);

  logic [NumCorners*16-1:0] corners_q, corners_d;
  logic [7:0] case_q, case_d;
  logic [3:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic       corner_hi;

  // The one comparator looks at the lowest corner of the shift register.
  assign corner_hi = corners_q[15:0] > level_i;

  always_comb begin
    corners_d = corners_q;
    case_d    = case_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    if (start_i) begin
      corners_d = corners_i;
      cnt_d     = '0;
      busy_d    = 1'b1;
    end else if (busy_q) begin
      corners_d = corners_q >> 16;
      case_d    = {corner_hi, case_q[7:1]};
      cnt_d     = cnt_q + 4'd1;
      if (cnt_q == 4'(NumCorners - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    corners_q <= corners_d;
    case_q    <= case_d;
  end

  assign done_o = busy_q && (cnt_q == 4'(NumCorners - 1));
  assign case_o = {corner_hi, case_q[7:1]};

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < 4'(NumCorners)) else $error("classifier count overrun");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !start_i |=> !busy_q) else $error("classifier did not stop");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0) else $error("classifier start lost");
`endif

endmodule

@@ sv/marching_cubes_cell_triangulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marching cubes cell triangulator
// Classifies one cube and emits its triangle vertices from the standard
// tables, one vertex per output request.
// ----------------------------------------------------------------------------
// Usage: a cube request enters on cube_valid_i/cube_stall_o with its origin
// and eight corner densities. The classifier compares one corner a cycle,
// so case index and edge mask are ready once all eight corners are compared.
// The vertex sequencer then walks the triangle table row and presents one
// vertex request per cycle while the receiver does not stall, on
// vert_valid_o/vert_stall_i; a vertex is taken at an edge with valid high
// and stall low. A cube yields 0 to 15 vertices. cube_stall_o is high from
// acceptance until the block is idle again.
// A cube with no triangles produces no vertex request.
// Receiver stall holds the current vertex in the output register and
// freezes the sequencer. The surface level register is written with
// level_we_i; the user must write it only while idle, and the block itself
// does not enforce that. Reset sets it to 1500 and empties the block.
// ----------------------------------------------------------------------------
module marching_cubes_cell_triangulator
  import mcct_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cube_valid_i,
  output logic        cube_stall_o,
  input  cube_req_t   cube_i,
  output logic        vert_valid_o,
  input  logic        vert_stall_i,
  output vertex_req_t vert_o,
  input  logic        level_we_i,
  input  logic [15:0] level_i
);

  localparam int unsigned LimRaw = 2 * (GRID_SIZE - 1);
  localparam logic [8:0]  Lim    = (LimRaw > 511) ? 9'd511 : 9'(LimRaw);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StClass = 4'b0010,
    StEmit  = 4'b0100,
    StLast  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] level_q;
  logic [7:0]  x_q, y_q, z_q;
  logic [7:0]  case_q;
  tri_row_t    row_q;
  tri_row_t    cls_row;
  logic [3:0]  k_q, k_d;
  logic [1:0]  tri_q, tri_d;
  logic        accept, cls_done, out_take;
  logic [7:0]  cls_case;
  vertex_req_t out_q, out_d;
  logic        out_v_q, out_v_d;
  logic [3:0]  e;
  logic [5:0]  mid;

  assign accept   = cube_valid_i && !cube_stall_o;
  assign out_take = out_v_q && !vert_stall_i;

  mcct_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .corners_i({cube_i.corner_7, cube_i.corner_6, cube_i.corner_5,
                cube_i.corner_4, cube_i.corner_3, cube_i.corner_2,
                cube_i.corner_1, cube_i.corner_0}),
    .level_i  (level_q),
    .done_o   (cls_done),
    .case_o   (cls_case)
  );

  // Table row of the freshly classified cube.
  assign cls_row = tri_row(cls_case);

  // Saturating doubled coordinate.
  function automatic logic [8:0] coord2(input logic [7:0] o, input logic [1:0] off);
    logic [9:0] v;
    begin
      v = {1'b0, o, 1'b0} + 10'(off);
      return (v > 10'(Lim)) ? Lim : v[8:0];
    end
  endfunction

  // Current edge and its geometry.
  assign e   = row_q.edges[k_q*4 +: 4];
  assign mid = edge_mid2(e);

  // Sequencer: one vertex is loaded each time the output register is free.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    tri_d   = tri_q;
    out_d   = out_q;
    out_v_d = out_v_q && !out_take;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StClass;
      end
      StClass: begin
        if (cls_done) begin
          k_d     = '0;
          tri_d   = '0;
          state_d = (cls_row.count == 4'd0) ? StIdle : StEmit;
        end
      end
      StEmit: begin
        if (!out_v_q || out_take) begin
          out_v_d            = 1'b1;
          out_d.vertex_x2    = coord2(x_q, mid[5:4]);
          out_d.vertex_y2    = coord2(y_q, mid[3:2]);
          out_d.vertex_z2    = coord2(z_q, mid[1:0]);
          out_d.edge_index   = e;
          out_d.case_index   = case_q;
          out_d.crossed_edges = edge_mask(case_q);
          out_d.triangle_end = (tri_q == 2'd2);
          out_d.cube_last    = (k_q + 4'd1 == row_q.count);
          k_d                = k_q + 4'd1;
          tri_d              = (tri_q == 2'd2) ? 2'd0 : tri_q + 2'd1;
          if (k_q + 4'd1 == row_q.count) state_d = StLast;
        end
      end
      StLast: begin
        if (out_take) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      level_q <= 16'd1500;
      k_q     <= '0;
      tri_q   <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      k_q     <= k_d;
      tri_q   <= tri_d;
      if (level_we_i) level_q <= level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      x_q <= cube_i.cube_x;
      y_q <= cube_i.cube_y;
      z_q <= cube_i.cube_z;
    end
    if (state_q == StClass && cls_done) begin
      case_q <= cls_case;
      row_q  <= cls_row;
    end
  end

  assign cube_stall_o = (state_q != StIdle);
  assign vert_valid_o = out_v_q;
  assign vert_o       = out_q;

`ifndef SYNTHESIS
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> k_q < 4'(MaxVerts)) else $error("vertex index overrun");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_q.cube_last |=> state_q == StIdle) else $error("cube end lost");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !out_v_q) else $error("vertex pending while idle");
`endif

endmodule
